// ===== rtl/core/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types, constants and functions of the hex record CRC block.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0]  StartCode = 8'h3A;  // ':'
  localparam logic [7:0]  LowerBase = 8'h57;  // 'W'
  localparam logic [7:0]  UpperBase = 8'h37;  // '7'
  localparam logic [7:0]  DigitBase = 8'h30;  // '0'
  localparam logic [7:0]  LowerA    = 8'h61;  // 'a'
  localparam logic [7:0]  UpperA    = 8'h41;  // 'A'
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcInit   = 16'h0000;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDRH = 3'd2,
    PH_ADDRL = 3'd3,
    PH_TYPE  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CSUM  = 3'd6
  } phase_e;

  // work passed from the parser to the CRC unit
  typedef struct packed {
    logic       fold;
    logic       emit;
    logic [7:0] data;
  } op_t;

  function automatic logic [7:0] digit_value(input logic [7:0] ch);
    logic [7:0] v;
    if (ch >= LowerA) begin
      v = ch - LowerBase;
    end else if (ch >= UpperA) begin
      v = ch - UpperBase;
    end else begin
      v = ch - DigitBase;
    end
    return v;
  endfunction

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/hrc_chan_if.sv =====
// ----------------------------------------------------------------------------
// hrc_chan_if
// Valid/ready channels: character items in, CRC result items out.
// ----------------------------------------------------------------------------
interface hrc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface hrc_crc_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_result;

  modport source (output valid, output crc_result, input ready);
  modport sink   (input valid, input crc_result, output ready);
endinterface

// ===== rtl/core/hrc_parser.sv =====
// ----------------------------------------------------------------------------
// hrc_parser
// Front end: walks the record structure and issues data bytes and
// end-of-stream marks to the queue.
// ----------------------------------------------------------------------------
module hrc_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  hrc_char_if.sink     char_i,
  input  logic         q_full_i,
  output logic         push_o,
  output hrc_pkg::op_t op_o
);
  import hrc_pkg::*;

  phase_e     phase_q, phase_d;
  logic       pend_q, pend_d;
  logic [7:0] high_q, high_d;
  logic [7:0] left_q, left_d;

  logic       accept;
  logic [7:0] dv;
  logic [7:0] byte_val;
  logic       in_record;

  assign char_i.ready = !q_full_i;
  assign accept       = char_i.valid && char_i.ready;
  assign dv           = digit_value(char_i.char_code);
  assign byte_val     = {high_q[3:0], 4'b0000} | dv;
  assign in_record    = (phase_q != PH_SEEK) && (phase_q <= PH_CSUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      pend_q  <= 1'b0;
      high_q  <= 8'h00;
      left_q  <= 8'h00;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      high_q  <= high_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pend_d    = pend_q;
    high_d    = high_q;
    left_d    = left_q;
    push_o    = 1'b0;
    op_o.fold = 1'b0;
    op_o.emit = 1'b0;
    op_o.data = byte_val;
    if (accept) begin
      if (!in_record) begin
        phase_d = PH_SEEK;
        if (char_i.char_code == StartCode) begin
          phase_d = PH_COUNT;
          pend_d  = 1'b0;
        end
      end else if (!pend_q) begin
        high_d = dv;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
        case (phase_q)
          PH_COUNT: begin
            left_d  = byte_val;
            phase_d = PH_ADDRH;
          end
          PH_ADDRH: phase_d = PH_ADDRL;
          PH_ADDRL: phase_d = PH_TYPE;
          PH_TYPE:  phase_d = (left_q != 8'h00) ? PH_DATA : PH_CSUM;
          PH_DATA: begin
            op_o.fold = 1'b1;
            left_d    = left_q - 8'h01;
            if (left_q == 8'h01) begin
              phase_d = PH_CSUM;
            end
          end
          default:  phase_d = PH_SEEK;
        endcase
      end
      if (char_i.end_of_input) begin
        op_o.emit = 1'b1;
        phase_d   = PH_SEEK;
        pend_d    = 1'b0;
        high_d    = 8'h00;
        left_d    = 8'h00;
      end
      push_o = op_o.fold || op_o.emit;
    end
  end

endmodule

// ===== rtl/core/hrc_fifo.sv =====
// ----------------------------------------------------------------------------
// hrc_fifo
// Short queue of operations between the parser and the CRC unit.
// ----------------------------------------------------------------------------
module hrc_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hrc_pkg::op_t op_i,
  output logic         full_o,
  output logic         valid_o,
  output hrc_pkg::op_t op_o,
  input  logic         pop_i
);
  import hrc_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/hrc_crc_unit.sv =====
// ----------------------------------------------------------------------------
// hrc_crc_unit
// Back end: folds data bytes into the CRC and holds the result item.
// ----------------------------------------------------------------------------
module hrc_crc_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  hrc_pkg::op_t op_i,
  output logic         pop_o,
  hrc_crc_if.source    crc_o
);
  import hrc_pkg::*;

  logic [15:0] crc_q;
  logic [15:0] crc_d;
  logic [15:0] res_q;
  logic        out_valid_q;

  assign crc_d = op_i.fold ? crc_fold(crc_q, op_i.data) : crc_q;
  assign pop_o = op_valid_i && (!op_i.emit || !out_valid_q || crc_o.ready);

  assign crc_o.valid      = out_valid_q;
  assign crc_o.crc_result = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        crc_q <= op_i.emit ? CrcInit : crc_d;
      end
      if (pop_o && op_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (crc_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.emit) begin
      res_q <= crc_d;
    end
  end

endmodule

// ===== rtl/core/hex_record_data_crc16.sv =====
// ----------------------------------------------------------------------------
// hex_record_data_crc16
// CRC-16 (reflected, poly 0xA001, start 0) over the data bytes of an
// Intel HEX character stream.
//
// char_i takes one text character per item; end_of_input marks the last
// character of a stream. crc_o gives one item per stream: the CRC over all
// completed data bytes of all records seen, after which the CRC restarts.
// Throughput is one character per cycle; the parser only stalls when the
// four-entry operation queue is full. With the queue empty, the op for the
// last character is written to the queue when that character is accepted
// and then moves into the CRC unit's result register, where the result
// becomes valid. A stalled receiver holds the result register; the CRC unit
// keeps folding data bytes and only waits when a second result is due, and
// the parser keeps taking characters until the queue fills.
// Reset returns the parser to seeking ':' and clears CRC and queue.
// ----------------------------------------------------------------------------
module hex_record_data_crc16 (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrc_char_if.sink  char_i,
  hrc_crc_if.source crc_o
);
  import hrc_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic q_valid;
  op_t  q_op;
  logic pop;

  hrc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (push_op)
  );

  hrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_op),
    .pop_i   (pop)
  );

  hrc_crc_unit u_crc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .pop_o      (pop),
    .crc_o      (crc_o)
  );

endmodule
